[sv/stg_pkg.sv]
// Shared types, register codes and elaboration-time math for the tone generator.
// No dependencies; the tone generator core imports this package.
`timescale 1ns / 1ps

package stg_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 32;
    localparam int FRAME_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP,
        REG_FRAME_TOTAL
    } cfg_reg_t;

    // Mix weights in Q1.15, 0.7 and 0.3; they sum to one
    localparam int WEIGHT_SINE = 22938;
    localparam int WEIGHT_TRI  = 9830;
    localparam int ROUND_HALF  = 16384;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Two truncating Q2.30 multiplies: term * x * x
    function automatic logic [63:0] taylor_mul(logic [63:0] term, logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // Odd Taylor series of sin(x), nine terms, x in Q2.30
    function automatic logic [63:0] sine_q30(logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = x;
        term = taylor_mul(x, x) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_mul(term, x) / 64'd20;
        sum  = sum + term;
        term = taylor_mul(term, x) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_mul(term, x) / 64'd72;
        sum  = sum + term;
        term = taylor_mul(term, x) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_mul(term, x) / 64'd156;
        sum  = sum + term;
        term = taylor_mul(term, x) / 64'd210;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = taylor_mul(term, x) / 64'd272;
        sum  = sum + term;
        return sum;
    endfunction

    // Quarter-wave entry k of a table with 2^qtr_bits steps per quarter
    function automatic logic [63:0] sine_entry(int k, int qtr_bits, logic [63:0] fs);
        logic [63:0] x;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(k)) >> qtr_bits;
        v = (sine_q30(x) * fs + (64'd1 << 29)) >> 30;
        if (v > fs)
        begin
            v = fs;
        end
        return v;
    endfunction

endpackage

[sv/stg_in_if.sv]
// Input channel of the tone generator: one item requests one frame.
// Depends on nothing.
`timescale 1ns / 1ps

interface stg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

[sv/stg_out_if.sv]
// Output channel of the tone generator: one item is one stereo frame.
// Depends on nothing; SAMPLE_BITS must match the core.
`timescale 1ns / 1ps

interface stg_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          sample_valid;
    logic                          last_frame;

    modport source (output valid, output left_sample, output right_sample,
                    output sample_valid, output last_frame, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input sample_valid, input last_frame, output ready);
endinterface

[sv/stg_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module stg_ram #(
    parameter int  WIDTH = 15,
    parameter int  DEPTH = 257,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/sine_triangle_tone_generator_core.sv]
// Sine/triangle test-tone core: phase accumulator, quarter-wave sine RAM, 0.7/0.3 mixer.
// Depends on stg_pkg, stg_in_if, stg_out_if and stg_ram.
// A frame passes the stage 1, stage 2, stage 3 and output registers after its request item is accepted.
// Throughput: one frame per cycle while ctrl.ready is high; the phase/count update in the accept stage sets that rate.
// Reset: asynchronous, active low; clears phase, frame count and registers, then loads
// the 2^(SINE_TABLE_BITS-2)+1 sine RAM entries (257 by default) with ready held low.
`timescale 1ns / 1ps

module sine_triangle_tone_generator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]    cfg_data,
    stg_in_if.sink                            ctrl,
    stg_out_if.source                         frame
);

    import stg_pkg::*;

    // Table geometry: entries 0..QTR of one quarter wave
    localparam int QB    = SINE_TABLE_BITS - 2;
    localparam int QTR   = 1 << QB;
    localparam int DEPTH = QTR + 1;
    localparam int AW    = QB + 1;
    localparam int TW    = SAMPLE_BITS - 1;
    localparam int FS    = (1 << (SAMPLE_BITS - 1)) - 1;

    // Mixer widths: products and sum fit in ACC_W, floor shift leaves SH_W
    localparam int ACC_W = SAMPLE_BITS + 17;
    localparam int SH_W  = ACC_W - 15;
    localparam int MW    = 24 + TW;

    localparam logic signed [SH_W-1:0]        SAT_HI = SH_W'(FS);
    localparam logic signed [SH_W-1:0]        SAT_LO = SH_W'(-FS - 1);
    localparam logic signed [SAMPLE_BITS-1:0] FS_S   = SAMPLE_BITS'(FS);
    localparam logic signed [ACC_W-1:0]       W_SIN  = ACC_W'(WEIGHT_SINE);
    localparam logic signed [ACC_W-1:0]       W_TRI  = ACC_W'(WEIGHT_TRI);
    localparam logic signed [ACC_W-1:0]       RND    = ACC_W'(ROUND_HALF);

    typedef logic [TW-1:0] sine_tab_t [DEPTH];

    // Sine contents, worked out at elaboration and copied into the RAM after reset
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k < DEPTH; k++)
        begin
            tab[k] = TW'(sine_entry(k, QB, 64'(FS)));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // Per-stage control that travels with each item
    typedef struct packed {
        logic vld;   // stage holds an item
        logic tone;  // frame lies inside the tone
        logic last;  // final frame of the tone
    } flags_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [FRAME_W-1:0]    frame_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            frame_total_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PHASE_STEP:  phase_step_reg  <= PHASE_BITS'(cfg_data[STEP_W-1:0]);
                REG_FRAME_TOTAL: frame_total_reg <= cfg_data[FRAME_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sine RAM load after reset
    // ------------------------------------------------------------------
    logic          fill_busy_reg;
    logic [AW-1:0] fill_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
        end
        else if (fill_busy_reg)
        begin
            // drop busy once the last entry is written
            if (fill_cnt_reg == AW'(QTR))
            begin
                fill_busy_reg <= 1'b0;
            end
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: phase and frame count update
    // ------------------------------------------------------------------
    logic                  out_vld_reg;
    logic                  adv;
    logic                  acc_go;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [FRAME_W-1:0]    count_reg;
    logic [FRAME_W-1:0]    count_next;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [FRAME_W-1:0]    cur_count;
    logic                  tone_on;
    logic                  tone_last;
    logic [1:0]            cur_quad;
    logic [QB-1:0]         cur_idx;
    logic [AW-1:0]         rom_addr;
    logic [23:0]           cur_r24;

    // The whole pipeline advances whenever the output register can take an item
    assign adv        = !out_vld_reg || frame.ready;
    assign ctrl.ready = !fill_busy_reg && adv;
    assign acc_go     = ctrl.valid && ctrl.ready;

    // Restart clears phase and count ahead of this frame
    assign cur_phase = ctrl.restart ? '0 : phase_reg;
    assign cur_count = ctrl.restart ? '0 : count_reg;
    assign tone_on   = cur_count < frame_total_reg;
    assign tone_last = ({1'b0, cur_count} + 1'b1) == {1'b0, frame_total_reg};

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (acc_go)
        begin
            phase_next = cur_phase;
            count_next = cur_count;
            // advance only inside the tone; a finished tone holds
            if (tone_on)
            begin
                phase_next = cur_phase + phase_step_reg;
                count_next = cur_count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Quadrant, mirrored table address and 24-bit position within the quarter
    assign cur_quad = cur_phase[PHASE_BITS-1 -: 2];
    assign cur_idx  = cur_phase[PHASE_BITS-3 -: QB];
    assign rom_addr = cur_quad[0] ? (AW'(QTR) - {1'b0, cur_idx}) : {1'b0, cur_idx};

    generate
        if (PHASE_BITS >= 26)
        begin : g_r24_down
            assign cur_r24 = cur_phase[PHASE_BITS-3 -: 24];
        end
        else
        begin : g_r24_up
            assign cur_r24 = {cur_phase[PHASE_BITS-3:0], {(26 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    logic [TW-1:0] rom_data;

    stg_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_sine_ram (
        .clk   (clk),
        .we    (fill_busy_reg),
        .waddr (fill_cnt_reg),
        .wdata (SINE_TAB[fill_cnt_reg]),
        .re    (adv),
        .raddr (rom_addr),
        .rdata (rom_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: RAM data arrives; form signed sine and triangle
    // ------------------------------------------------------------------
    flags_t      s1_flags_reg;
    logic [1:0]  s1_quad_reg;
    logic [23:0] s1_r24_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_flags_reg <= '0;
        end
        else if (adv)
        begin
            s1_flags_reg <= '{vld: acc_go, tone: tone_on, last: tone_last};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_quad_reg <= cur_quad;
            s1_r24_reg  <= cur_r24;
        end
    end

    logic [MW-1:0]                 m_prod;
    logic signed [SAMPLE_BITS-1:0] m_s;
    logic signed [SAMPLE_BITS-1:0] sine_pos;
    logic signed [SAMPLE_BITS-1:0] sine_val;
    logic signed [SAMPLE_BITS-1:0] tri_val;

    assign m_prod   = MW'(s1_r24_reg) * MW'(FS);
    assign m_s      = {1'b0, m_prod[MW-1:24]};
    assign sine_pos = {1'b0, rom_data};
    assign sine_val = s1_quad_reg[1] ? -sine_pos : sine_pos;

    always_comb
    begin
        case (s1_quad_reg)
            2'd0:    tri_val = m_s;
            2'd1:    tri_val = FS_S - m_s;
            2'd2:    tri_val = -m_s;
            default: tri_val = m_s - FS_S;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 2: weight both waves
    // ------------------------------------------------------------------
    flags_t                        s2_flags_reg;
    logic signed [SAMPLE_BITS-1:0] s2_sine_reg;
    logic signed [SAMPLE_BITS-1:0] s2_tri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_flags_reg <= '0;
        end
        else if (adv)
        begin
            s2_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sine_reg <= sine_val;
            s2_tri_reg  <= tri_val;
        end
    end

    logic signed [ACC_W-1:0] prod_sine;
    logic signed [ACC_W-1:0] prod_tri;

    assign prod_sine = ACC_W'(s2_sine_reg) * W_SIN;
    assign prod_tri  = ACC_W'(s2_tri_reg) * W_TRI;

    // ------------------------------------------------------------------
    // Stage 3: sum, round, floor shift and saturate
    // ------------------------------------------------------------------
    flags_t                  s3_flags_reg;
    logic signed [ACC_W-1:0] s3_sine_reg;
    logic signed [ACC_W-1:0] s3_tri_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_flags_reg <= '0;
        end
        else if (adv)
        begin
            s3_flags_reg <= s2_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sine_reg <= prod_sine;
            s3_tri_reg  <= prod_tri;
        end
    end

    logic signed [ACC_W-1:0]       mix_sum;
    logic signed [SH_W-1:0]        mix_sh;
    logic signed [SAMPLE_BITS-1:0] mix_sat;

    assign mix_sum = s3_sine_reg + s3_tri_reg + RND;
    assign mix_sh  = mix_sum[ACC_W-1:15];

    always_comb
    begin
        if (mix_sh > SAT_HI)
        begin
            mix_sat = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (mix_sh < SAT_LO)
        begin
            mix_sat = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            mix_sat = mix_sh[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: hold the frame until the sink takes it
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          tone_reg;
    logic                          last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= s3_flags_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // a finished tone emits silence with both flags low
            sample_reg <= s3_flags_reg.tone ? mix_sat : '0;
            tone_reg   <= s3_flags_reg.tone;
            last_reg   <= s3_flags_reg.tone && s3_flags_reg.last;
        end
    end

    assign frame.valid        = out_vld_reg;
    assign frame.left_sample  = sample_reg;
    assign frame.right_sample = sample_reg;
    assign frame.sample_valid = tone_reg;
    assign frame.last_frame   = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_busy_reg |-> !ctrl.ready)
        else $error("item accepted while sine RAM loads");

    a_restart_counts_one: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_go && ctrl.restart && (frame_total_reg != '0)) |=> (count_reg == FRAME_W'(1)))
        else $error("restart did not emit frame zero");

    a_last_inside_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.last_frame) |-> frame.sample_valid)
        else $error("last frame flagged outside the tone");

    a_silent_after_tone: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && !frame.sample_valid) |-> (frame.left_sample == '0))
        else $error("nonzero sample outside the tone");

    a_count_holds_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_go && !ctrl.restart && (count_reg >= frame_total_reg))
        |=> $stable(count_reg) && $stable(phase_reg))
        else $error("state moved after the tone ended");

endmodule
